/* rtl/tnr_pkg.sv */
// ----------------------------------------------------------------------------
// tnr_pkg: shared types and constants of the truncated normal generator
// Function codes, state encodings, generator constants, arctan table, LCG step.
// ----------------------------------------------------------------------------
`default_nettype none
package tnr_pkg;

    // request function codes
    localparam logic [1:0] FUNC_NORMAL      = 2'd0;
    localparam logic [1:0] FUNC_PERT_POS    = 2'd1;
    localparam logic [1:0] FUNC_PERT_BOUNDS = 2'd2;

    // Park-Miller minimal standard generator
    localparam logic [14:0] LCG_MULT = 15'd16807;
    localparam logic [30:0] LCG_MOD  = 31'h7FFF_FFFF;

    // CORDIC start vector (gain-compensated), Q30
    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
    // 2 ln 2 in Q30
    localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_LCG_R,
        B_LCG_A,
        B_NORM,
        B_LOG,
        B_LNSUB,
        B_LNMUL,
        B_SQRT,
        B_CORD,
        B_RMUL,
        B_NSHIFT,
        B_MUL,
        B_SCALE,
        B_SUM,
        B_CHECK,
        B_OUT
    } back_state_t;

    // arctan(2^-i) in turns, 2^32 = one turn
    function automatic logic [31:0] atan_turns(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // one generator step: x * 16807 mod (2^31 - 1), Mersenne fold
    // the out-of-range seed 2^31 - 1 maps onto itself
    function automatic logic [30:0] lcg_step(input logic [30:0] x);
        logic [45:0] prod;
        logic [31:0] fold;
        logic [31:0] red;
        prod = 46'(x) * 46'(LCG_MULT);
        fold = {1'b0, prod[30:0]} + {17'd0, prod[45:31]};
        red  = (fold >= {1'b0, LCG_MOD}) ? (fold - {1'b0, LCG_MOD}) : fold;
        return (x == LCG_MOD) ? LCG_MOD : red[30:0];
    endfunction

endpackage
`default_nettype wire

/* rtl/tnr_fifo.sv */
// ----------------------------------------------------------------------------
// tnr_fifo: two-word queue
// Decouples producer and consumer; full and empty flags from an occupancy count.
// ----------------------------------------------------------------------------
`default_nettype none
module tnr_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    logic [WIDTH-1:0] entry0_reg;
    logic [WIDTH-1:0] entry1_reg;
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = rd_ptr_reg ? entry1_reg : entry0_reg;

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr && !wr_ptr_reg)
        begin
            entry0_reg <= wr_data;
        end
        if (do_wr && wr_ptr_reg)
        begin
            entry1_reg <= wr_data;
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/tnr_front.sv */
// ----------------------------------------------------------------------------
// tnr_front: request intake
// Takes a request word, derives mean and deviation (PERT divide by six,
// seven quotient bits per cycle) and queues the job for the draw engine.
// ----------------------------------------------------------------------------
`default_nettype none
module tnr_front
    import tnr_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [1:0]                    func,
    input  wire logic [30:0]                   seed,
    input  wire logic signed [VALUE_WIDTH-1:0] value_a,
    input  wire logic signed [VALUE_WIDTH-1:0] value_b,
    input  wire logic signed [VALUE_WIDTH-1:0] value_c,
    output logic                               job_push,
    output logic [4*VALUE_WIDTH+32:0]          job_data,
    input  wire logic                          job_full
);

    localparam int W1  = VALUE_WIDTH + 3;
    localparam int BPC = 7;
    localparam int NCH = (W1 + BPC - 1) / BPC;
    localparam int WN  = NCH * BPC;
    localparam int CW  = $clog2(NCH + 1);

    front_state_t                  state_reg;
    front_state_t                  state_next;
    logic [1:0]                    func_reg;
    logic [30:0]                   seed_reg;
    logic [VALUE_WIDTH-1:0]        a_reg;
    logic [VALUE_WIDTH-1:0]        b_reg;
    logic [VALUE_WIDTH-1:0]        c_reg;
    logic [WN-1:0]                 num1_reg;
    logic [WN-1:0]                 num2_reg;
    logic [2:0]                    rem1_reg;
    logic [2:0]                    rem2_reg;
    logic                          neg1_reg;
    logic                          neg2_reg;
    logic [CW-1:0]                 cnt_reg;

    logic                          accept;
    logic signed [W1-1:0]          sum_s;
    logic signed [W1-1:0]          diff_s;
    logic [W1-1:0]                 mag1;
    logic [W1-1:0]                 mag2;
    logic [BPC+2:0]                dv1;
    logic [BPC+2:0]                dv2;
    logic [WN-1:0]                 q1;
    logic [WN-1:0]                 q2;
    logic [VALUE_WIDTH-1:0]        mean_o;
    logic [VALUE_WIDTH-1:0]        dev_o;

    // one chunk of restoring divide-by-six: {remainder, quotient bits}
    function automatic logic [BPC+2:0] div6_chunk(input logic [2:0] rem,
                                                  input logic [BPC-1:0] bits);
        logic [2:0]     r;
        logic [3:0]     t;
        logic [BPC-1:0] q;
        r = rem;
        q = '0;
        for (int i = BPC - 1; i >= 0; i--)
        begin
            t = {r, bits[i]};
            if (t >= 4'd6)
            begin
                q[i] = 1'b1;
                r    = 3'(t - 4'd6);
            end
            else
            begin
                r = t[2:0];
            end
        end
        return {r, q};
    endfunction

    assign accept = push && !full;

    // PERT numerators: a + 4b + c and c - a
    assign sum_s  = W1'(value_a) + (W1'(value_b) <<< 2) + W1'(value_c);
    assign diff_s = W1'(value_c) - W1'(value_a);
    assign mag1   = sum_s[W1-1] ? (~sum_s + W1'(1)) : sum_s;
    assign mag2   = diff_s[W1-1] ? (~diff_s + W1'(1)) : diff_s;

    // divide-by-six step on the top chunk
    assign dv1 = div6_chunk(rem1_reg, num1_reg[WN-1 -: BPC]);
    assign dv2 = div6_chunk(rem2_reg, num2_reg[WN-1 -: BPC]);

    // quotients back to signed, truncated toward zero
    assign q1     = neg1_reg ? (~num1_reg + WN'(1)) : num1_reg;
    assign q2     = neg2_reg ? (~num2_reg + WN'(1)) : num2_reg;
    assign mean_o = (func_reg == FUNC_NORMAL) ? a_reg : q1[VALUE_WIDTH-1:0];
    assign dev_o  = (func_reg == FUNC_NORMAL) ? b_reg : q2[VALUE_WIDTH-1:0];
    assign job_data = {func_reg, seed_reg, mean_o, dev_o, a_reg, c_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = (func == FUNC_NORMAL) ? F_PUSH : F_DIV;
                end
            end
            F_DIV:
            begin
                if (cnt_reg == CW'(1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!job_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        full     = 1'b1;
        job_push = 1'b0;
        unique case (state_reg)
            F_IDLE: full = 1'b0;
            F_DIV:  full = 1'b1;
            F_PUSH: job_push = !job_full;
            default: full = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // request capture and divider
    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && accept)
        begin
            func_reg <= func;
            seed_reg <= seed;
            a_reg    <= value_a;
            b_reg    <= value_b;
            c_reg    <= value_c;
            neg1_reg <= sum_s[W1-1];
            neg2_reg <= diff_s[W1-1];
            num1_reg <= WN'(mag1);
            num2_reg <= WN'(mag2);
            rem1_reg <= 3'd0;
            rem2_reg <= 3'd0;
            cnt_reg  <= CW'(NCH);
        end
        else if (state_reg == F_DIV)
        begin
            rem1_reg <= dv1[BPC+2:BPC];
            rem2_reg <= dv2[BPC+2:BPC];
            num1_reg <= {num1_reg[WN-BPC-1:0], dv1[BPC-1:0]};
            num2_reg <= {num2_reg[WN-BPC-1:0], dv2[BPC-1:0]};
            cnt_reg  <= cnt_reg - CW'(1);
        end
    end

endmodule
`default_nettype wire

/* rtl/tnr_back.sv */
// ----------------------------------------------------------------------------
// tnr_back: draw engine
// Runs Box-Muller draws (generator, log, square root, CORDIC cosine, scaling)
// until one falls in range or the attempt limit is spent.
// ----------------------------------------------------------------------------
`default_nettype none
module tnr_back
    import tnr_pkg::*;
#(
    parameter int FRAC_BITS    = 16,
    parameter int VALUE_WIDTH  = 32,
    parameter int CORDIC_STEPS = 20
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     job_empty,
    output logic                          job_pop,
    input  wire logic [4*VALUE_WIDTH+32:0] job_data,
    input  wire logic [7:0]               max_attempts,
    input  wire logic                     res_full,
    output logic                          res_push,
    output logic [VALUE_WIDTH:0]          res_data
);

    localparam int VW      = VALUE_WIDTH;
    localparam int NSTEPS  = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int SHIFT_N = 54 - FRAC_BITS;
    localparam int NW      = FRAC_BITS + 5;
    localparam int HI_W    = (VW > 24) ? (VW - 24) : 1;
    localparam int LO_W    = (VW > 24) ? 24 : VW;
    localparam logic signed [63:0] S_MAX = 64'sd1 <<< (VW - 1);

    back_state_t              state_reg;
    back_state_t              state_next;
    logic [30:0]              lcg_reg;
    logic [1:0]               func_reg;
    logic signed [VW-1:0]     mean_reg;
    logic signed [VW-1:0]     dev_reg;
    logic signed [VW-1:0]     a_reg;
    logic signed [VW-1:0]     c_reg;
    logic [30:0]              mnt_reg;
    logic [4:0]               e_reg;
    logic [31:0]              frac_reg;
    logic [36:0]              d_reg;
    logic [5:0]               step_reg;
    logic [63:0]              rem_reg;
    logic [63:0]              res_reg;
    logic [63:0]              bit_reg;
    logic signed [33:0]       cx_reg;
    logic signed [33:0]       cy_reg;
    logic signed [33:0]       z_reg;
    logic                     neg_reg;
    logic signed [62:0]       prod_reg;
    logic [NW-1:0]            ub_reg;
    logic [VW-1:0]            ua_reg;
    logic                     negp_reg;
    logic [HI_W+NW-1:0]       hi_prod_reg;
    logic [LO_W+NW-1:0]       lo_prod_reg;
    logic [63:0]              mag_reg;
    logic signed [VW-1:0]     sample_reg;
    logic                     ok_reg;
    logic [7:0]               att_reg;

    logic [30:0]              lcg_new;
    logic [31:0]              ang;
    logic signed [33:0]       z0;
    logic [61:0]              sq;
    logic [31:0]              l2f;
    logic [59:0]              w_full;
    logic [63:0]              sq_try;
    logic                     sq_ge;
    logic [4:0]               ci;
    logic signed [33:0]       dx;
    logic signed [33:0]       dy;
    logic signed [33:0]       at;
    logic signed [33:0]       cosv;
    logic signed [62:0]       n63;
    logic signed [NW-1:0]     nt;
    logic [HI_W-1:0]          ua_hi;
    logic [LO_W-1:0]          ua_lo;
    logic signed [63:0]       scaled;
    logic signed [63:0]       s_sum;
    logic                     in_range;
    logic [7:0]               att_next;
    logic [7:0]               limit;
    logic                     last_step;

    // job fields
    logic [1:0]               j_func;
    logic [30:0]              j_seed;

    assign j_func = job_data[4*VW+32:4*VW+31];
    assign j_seed = job_data[4*VW+30:4*VW];

    // generator and angle fold
    assign lcg_new = lcg_step(lcg_reg);
    assign ang     = {lcg_new, 1'b0};
    assign z0      = {{2{ang[31]}}, ang};

    // log2 mantissa squaring
    assign sq = 62'(mnt_reg) * 62'(mnt_reg);

    // -2 ln u: log2 fraction alignment and scaling
    assign l2f    = frac_reg << (32 - NSTEPS);
    assign w_full = 60'(d_reg[36:8]) * 60'(TWO_LN2_Q30);

    // restoring square root step
    assign sq_try = res_reg + bit_reg;
    assign sq_ge  = (rem_reg >= sq_try);

    // CORDIC rotation step
    assign ci = step_reg[4:0];
    assign dx = cy_reg >>> ci;
    assign dy = cx_reg >>> ci;
    assign at = $signed({2'b00, atan_turns(ci)});
    assign cosv = neg_reg ? -cx_reg : cx_reg;

    // normal value and operand split for the deviation product
    assign n63   = prod_reg >>> SHIFT_N;
    assign nt    = n63[NW-1:0];
    assign ua_hi = HI_W'(ua_reg >> 24);
    assign ua_lo = ua_reg[LO_W-1:0];

    // offset and saturation
    assign scaled = negp_reg ? -$signed(mag_reg) : $signed(mag_reg);
    assign s_sum  = 64'(mean_reg) + scaled;

    // acceptance window per function
    always_comb
    begin
        case (func_reg)
            FUNC_NORMAL:   in_range = (sample_reg > 0) && (sample_reg <= c_reg);
            FUNC_PERT_POS: in_range = (sample_reg > 0);
            default:       in_range = (sample_reg >= a_reg) && (sample_reg <= c_reg);
        endcase
    end

    assign limit     = (max_attempts == 8'd0) ? 8'd1 : max_attempts;
    assign att_next  = att_reg + 8'd1;
    assign last_step = (step_reg == 6'(NSTEPS - 1));
    assign res_data  = {!ok_reg, sample_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:   if (!job_empty) state_next = B_LCG_R;
            B_LCG_R:  state_next = B_LCG_A;
            B_LCG_A:  state_next = B_NORM;
            B_NORM:   if (e_reg == 5'd0 || mnt_reg[30]) state_next = B_LOG;
            B_LOG:    if (last_step) state_next = B_LNSUB;
            B_LNSUB:  state_next = B_LNMUL;
            B_LNMUL:  state_next = B_SQRT;
            B_SQRT:   if (step_reg == 6'd31) state_next = B_CORD;
            B_CORD:   if (last_step) state_next = B_RMUL;
            B_RMUL:   state_next = B_NSHIFT;
            B_NSHIFT: state_next = B_MUL;
            B_MUL:    state_next = B_SCALE;
            B_SCALE:  state_next = B_SUM;
            B_SUM:    state_next = B_CHECK;
            B_CHECK:
            begin
                if (in_range || att_next == limit)
                begin
                    state_next = B_OUT;
                end
                else
                begin
                    state_next = B_LCG_R;
                end
            end
            B_OUT:    if (!res_full) state_next = B_IDLE;
            default:  state_next = B_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        job_pop  = 1'b0;
        res_push = 1'b0;
        unique case (state_reg)
            B_IDLE:  job_pop = !job_empty;
            B_OUT:   res_push = !res_full;
            default: job_pop = 1'b0;
        endcase
    end

    // control state and generator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            lcg_reg   <= 31'd1;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_IDLE && !job_empty && j_seed != 31'd0)
            begin
                lcg_reg <= j_seed;
            end
            else if (state_reg == B_LCG_R || state_reg == B_LCG_A)
            begin
                lcg_reg <= lcg_new;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                func_reg <= j_func;
                mean_reg <= job_data[4*VW-1:3*VW];
                dev_reg  <= job_data[3*VW-1:2*VW];
                a_reg    <= job_data[2*VW-1:VW];
                c_reg    <= job_data[VW-1:0];
                att_reg  <= 8'd0;
            end
            B_LCG_R:
            begin
                mnt_reg <= (lcg_new == 31'd0) ? 31'd1 : lcg_new;
                e_reg   <= 5'd30;
            end
            B_LCG_A:
            begin
                // fold to [-1/4, 1/4] turn; cosine negates when folded
                if (z0 > 34'sd1073741824)
                begin
                    z_reg   <= z0 - 34'sd2147483648;
                    neg_reg <= 1'b1;
                end
                else if (z0 < -34'sd1073741824)
                begin
                    z_reg   <= z0 + 34'sd2147483648;
                    neg_reg <= 1'b1;
                end
                else
                begin
                    z_reg   <= z0;
                    neg_reg <= 1'b0;
                end
                cx_reg <= GAIN_Q30;
                cy_reg <= 34'sd0;
            end
            B_NORM:
            begin
                // leading-one search, one bit per cycle
                if (e_reg != 5'd0 && !mnt_reg[30])
                begin
                    mnt_reg <= {mnt_reg[29:0], 1'b0};
                    e_reg   <= e_reg - 5'd1;
                end
                step_reg <= 6'd0;
                frac_reg <= 32'd0;
            end
            B_LOG:
            begin
                if (sq[61])
                begin
                    mnt_reg  <= sq[61:31];
                    frac_reg <= {frac_reg[30:0], 1'b1};
                end
                else
                begin
                    mnt_reg  <= sq[60:30];
                    frac_reg <= {frac_reg[30:0], 1'b0};
                end
                step_reg <= step_reg + 6'd1;
            end
            B_LNSUB:
            begin
                d_reg <= {5'd31, 32'd0} - {e_reg, l2f};
            end
            B_LNMUL:
            begin
                rem_reg  <= {10'd0, w_full[59:30], 24'd0};
                res_reg  <= 64'd0;
                bit_reg  <= 64'd1 << 62;
                step_reg <= 6'd0;
            end
            B_SQRT:
            begin
                if (sq_ge)
                begin
                    rem_reg <= rem_reg - sq_try;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg  <= bit_reg >> 2;
                step_reg <= (step_reg == 6'd31) ? 6'd0 : step_reg + 6'd1;
            end
            B_CORD:
            begin
                if (z_reg >= 0)
                begin
                    cx_reg <= cx_reg - dx;
                    cy_reg <= cy_reg + dy;
                    z_reg  <= z_reg - at;
                end
                else
                begin
                    cx_reg <= cx_reg + dx;
                    cy_reg <= cy_reg - dy;
                    z_reg  <= z_reg + at;
                end
                step_reg <= step_reg + 6'd1;
            end
            B_RMUL:
            begin
                prod_reg <= $signed({1'b0, res_reg[27:0]}) * cosv;
            end
            B_NSHIFT:
            begin
                ub_reg   <= nt[NW-1] ? NW'(-nt) : NW'(nt);
                ua_reg   <= dev_reg[VW-1] ? (~dev_reg + VW'(1)) : dev_reg;
                negp_reg <= dev_reg[VW-1] != nt[NW-1];
            end
            B_MUL:
            begin
                hi_prod_reg <= ua_hi * ub_reg;
                lo_prod_reg <= ua_lo * ub_reg;
            end
            B_SCALE:
            begin
                mag_reg <= (64'(hi_prod_reg) << (24 - FRAC_BITS))
                         + (64'(lo_prod_reg) >> FRAC_BITS);
            end
            B_SUM:
            begin
                if (s_sum > S_MAX - 64'sd1)
                begin
                    sample_reg <= VW'(S_MAX - 64'sd1);
                end
                else if (s_sum < -S_MAX)
                begin
                    sample_reg <= VW'(-S_MAX);
                end
                else
                begin
                    sample_reg <= s_sum[VW-1:0];
                end
            end
            B_CHECK:
            begin
                ok_reg  <= in_range;
                att_reg <= att_next;
            end
            default:
            begin
                ok_reg <= ok_reg;
            end
        endcase
    end

endmodule
`default_nettype wire

/* rtl/truncated_normal_random_generator.sv */
// ----------------------------------------------------------------------------
// truncated_normal_random_generator: Box-Muller sampler with range rejection
// Queue-style request and result channels, one configuration register.
// ----------------------------------------------------------------------------
// Usage:
//   Requests go in on push/full: a word is taken at a clock edge with push
//   high and full low. Results come out on empty/pop: the oldest word sits on
//   sample/gave_up while empty is low and leaves on an edge with pop high.
//   cfg_wr_en/cfg_wr_data write max_attempts (reset 64, 0 acts as 1).
// Draw sequence:
//   One draw runs the generator states, the leading-one search, the log2
//   squaring steps, the log scaling states, the square-root steps, the
//   CORDIC cosine steps, then scaling and the range check. A word needs
//   one to max_attempts draws plus a pop state and an output state in the
//   draw engine. PERT words add a divide-by-six pass in the intake,
//   overlapped with the engine through a two-word job queue.
// Reset clears all queues; the generator state returns to 1.
// A stalled receiver fills the two-word result queue, then the engine, then
// the job queue, and finally full rises on the request side.
// ----------------------------------------------------------------------------
`default_nettype none
module truncated_normal_random_generator
    import tnr_pkg::*;
#(
    parameter int FRAC_BITS    = 16,
    parameter int VALUE_WIDTH  = 32,
    parameter int CORDIC_STEPS = 20
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [1:0]                    func,
    input  wire logic [30:0]                   seed,
    input  wire logic signed [VALUE_WIDTH-1:0] value_a,
    input  wire logic signed [VALUE_WIDTH-1:0] value_b,
    input  wire logic signed [VALUE_WIDTH-1:0] value_c,
    output logic                               empty,
    input  wire logic                          pop,
    output logic signed [VALUE_WIDTH-1:0]      sample,
    output logic                               gave_up,
    input  wire logic                          cfg_wr_en,
    input  wire logic [7:0]                    cfg_wr_data
);

    localparam int JOB_W = 4 * VALUE_WIDTH + 33;

    logic [7:0]             max_attempts_reg;
    logic                   job_push;
    logic [JOB_W-1:0]       job_wdata;
    logic                   job_full;
    logic                   job_pop;
    logic [JOB_W-1:0]       job_rdata;
    logic                   job_empty;
    logic                   res_push;
    logic [VALUE_WIDTH:0]   res_wdata;
    logic                   res_full;
    logic [VALUE_WIDTH:0]   res_rdata;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_attempts_reg <= 8'd64;
        end
        else if (cfg_wr_en)
        begin
            max_attempts_reg <= cfg_wr_data;
        end
    end

    // request intake
    tnr_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .func     (func),
        .seed     (seed),
        .value_a  (value_a),
        .value_b  (value_b),
        .value_c  (value_c),
        .job_push (job_push),
        .job_data (job_wdata),
        .job_full (job_full)
    );

    // job queue
    tnr_fifo #(
        .WIDTH (JOB_W)
    ) u_job_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_wdata),
        .full    (job_full),
        .rd_en   (job_pop),
        .rd_data (job_rdata),
        .empty   (job_empty)
    );

    // draw engine
    tnr_back #(
        .FRAC_BITS    (FRAC_BITS),
        .VALUE_WIDTH  (VALUE_WIDTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_empty    (job_empty),
        .job_pop      (job_pop),
        .job_data     (job_rdata),
        .max_attempts (max_attempts_reg),
        .res_full     (res_full),
        .res_push     (res_push),
        .res_data     (res_wdata)
    );

    // result queue
    tnr_fifo #(
        .WIDTH (VALUE_WIDTH + 1)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_wdata),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_rdata),
        .empty   (empty)
    );

    assign sample  = res_rdata[VALUE_WIDTH-1:0];
    assign gave_up = res_rdata[VALUE_WIDTH];

endmodule
`default_nettype wire

/* rtl/tnr_checker.sv */
// ----------------------------------------------------------------------------
// tnr_checker: port-level checks of the generator
// Result hold under stall, intake busy after accept, clean state after reset.
// ----------------------------------------------------------------------------
`default_nettype none
module tnr_checker #(
    parameter int VALUE_WIDTH = 32
) (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   push,
    input wire logic                   full,
    input wire logic                   empty,
    input wire logic                   pop,
    input wire logic [VALUE_WIDTH-1:0] sample,
    input wire logic                   gave_up
);

    // a waiting result stays until taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result word dropped while stalled");

    // a stalled result word does not change
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> ($stable(sample) && $stable(gave_up)))
        else $error("result word changed while stalled");

    // intake goes busy after taking a request
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> full)
        else $error("intake ready right after accepting a word");

    // queues come out of reset empty and ready
    a_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> (empty && !full))
        else $error("queues not clear after reset");

endmodule

bind truncated_normal_random_generator tnr_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_tnr_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .sample  (sample),
    .gave_up (gave_up)
);
`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of truncated_normal_random_generator
// A directed stimulus table, then phases of random requests under several
// attempt limits. Both queue sides idle at random. Every result word is
// checked against a bit-exact Box-Muller / Park-Miller predictor.
// ----------------------------------------------------------------------------
module tb;
    import tnr_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int         STEPS       = 20;
    localparam int         FRAC        = 16;
    localparam int         WDOG_LIMIT  = 300000;

    typedef struct {
        logic [1:0]         func;
        logic [30:0]        seed;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        bit                 has_s;
        logic signed [31:0] exp_s;
        bit                 has_g;
        bit                 exp_g;
    } req_t;

    typedef struct {
        logic signed [31:0] sample;
        logic               gave_up;
    } draw_out_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [1:0]         func = '0;
    logic [30:0]        seed = '0;
    logic signed [31:0] value_a = '0;
    logic signed [31:0] value_b = '0;
    logic signed [31:0] value_c = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic signed [31:0] sample;
    logic               gave_up;
    logic               cfg_wr_en = 1'b0;
    logic [7:0]         cfg_wr_data = '0;

    // predictor state
    logic [30:0]        lcg_model;
    logic [7:0]         attempts_model;
    draw_out_t          pending_q[$];
    req_t               cur_req;
    int                 fail_cnt = 0;
    bit                 send_burst = 1'b0;
    bit                 recv_burst = 1'b0;
    int                 idle_cycles = 0;

    longint atan_tab[32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0};

    truncated_normal_random_generator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .func        (func),
        .seed        (seed),
        .value_a     (value_a),
        .value_b     (value_b),
        .value_c     (value_c),
        .empty       (empty),
        .pop         (pop),
        .sample      (sample),
        .gave_up     (gave_up),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #2 clk = ~clk;

    // Park-Miller step, Schrage form
    function automatic logic [30:0] lcg_advance();
        longint x;
        longint t;
        x = longint'(lcg_model);
        t = 64'sd16807 * (x % 127773) - 64'sd2836 * (x / 127773);
        lcg_model = (t > 0) ? t[30:0] : 31'(t + 64'sd2147483647);
        return lcg_model;
    endfunction

    // -2 ln(x / 2^31), Q24
    function automatic bit [63:0] neg_two_ln(input logic [30:0] x);
        bit [30:0] xx;
        int        e;
        bit [63:0] mnt;
        bit [63:0] frac;
        bit [63:0] d;
        xx = (x == 0) ? 31'd1 : x;
        e = 30;
        frac = 0;
        while (e > 0 && !xx[e])
            e--;
        mnt = 64'(xx) << (30 - e);
        for (int k = 0; k < STEPS; k++)
        begin
            mnt = (mnt * mnt) >> 30;
            frac = frac << 1;
            if (mnt >= 64'h8000_0000)
            begin
                frac = frac | 64'd1;
                mnt = mnt >> 1;
            end
        end
        d = (64'd31 << 32) - ((64'(e) << 32) | (frac << (32 - STEPS)));
        return ((d >> 8) * 64'd1488522236) >> 30;
    endfunction

    function automatic bit [63:0] root64(input bit [63:0] v);
        bit [63:0] res;
        bit [63:0] bt;
        res = 0;
        bt = 64'd1 << 62;
        for (int k = 0; k < 32; k++)
        begin
            if (v >= res + bt)
            begin
                v = v - (res + bt);
                res = (res >> 1) + bt;
            end
            else
                res = res >> 1;
            bt = bt >> 2;
        end
        return res;
    endfunction

    // cosine of an angle in turns, Q30
    function automatic longint cos_q30(input bit [31:0] ang);
        longint z;
        longint cx;
        longint cy;
        longint dx;
        longint dy;
        bit     flip;
        z = ang[31] ? longint'(ang) - 64'sd4294967296 : longint'(ang);
        cx = 652032874;
        cy = 0;
        flip = 1'b0;
        if (z > (64'sd1 << 30))
        begin
            z = z - (64'sd1 << 31);
            flip = 1'b1;
        end
        else if (z < -(64'sd1 << 30))
        begin
            z = z + (64'sd1 << 31);
            flip = 1'b1;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (z >= 0)
            begin
                cx = cx - dx; cy = cy + dy; z = z - atan_tab[i];
            end
            else
            begin
                cx = cx + dx; cy = cy - dy; z = z + atan_tab[i];
            end
        end
        return flip ? -cx : cx;
    endfunction

    function automatic longint gauss_draw(input longint mean, input longint dev);
        bit [63:0] r;
        longint    cs;
        longint    n;
        bit [63:0] ua;
        bit [63:0] ub;
        bit [63:0] mag;
        longint    s;
        r = root64(neg_two_ln(lcg_advance()) << 24);
        cs = cos_q30({lcg_advance(), 1'b0});
        n = (longint'(r) * cs) >>> (54 - FRAC);
        ua = (dev < 0) ? -dev : dev;
        ub = (n < 0) ? -n : n;
        mag = (((ua >> 24) * ub) << (24 - FRAC)) + (((ua & 64'hFF_FFFF) * ub) >> FRAC);
        s = ((dev < 0) != (n < 0)) ? -longint'(mag) : longint'(mag);
        s = mean + s;
        if (s > 64'sd2147483647)
            s = 64'sd2147483647;
        if (s < -64'sd2147483648)
            s = -64'sd2147483648;
        return s;
    endfunction

    function automatic draw_out_t predict_sample(input req_t w);
        draw_out_t o;
        longint    a;
        longint    b;
        longint    c;
        longint    mean;
        longint    dev;
        longint    s;
        int        lim;
        bit        ok;
        a = w.a;
        b = w.b;
        c = w.c;
        s = 0;
        ok = 1'b0;
        lim = (attempts_model == 0) ? 1 : attempts_model;
        if (w.seed != 0)
            lcg_model = w.seed;
        if (w.func == FUNC_NORMAL)
        begin
            mean = a;
            dev = b;
        end
        else
        begin
            mean = (a + 4 * b + c) / 6;
            dev = (c - a) / 6;
        end
        for (int k = 0; k < lim && !ok; k++)
        begin
            s = gauss_draw(mean, dev);
            if (w.func == FUNC_NORMAL)
                ok = s > 0 && s <= c;
            else if (w.func == FUNC_PERT_POS)
                ok = s > 0;
            else
                ok = s >= a && s <= c;
        end
        o.sample = s[31:0];
        o.gave_up = !ok;
        return o;
    endfunction

    // request side: predict each accepted word
    always @(posedge clk)
    begin
        draw_out_t o;
        if (rst_n && push && !full)
        begin
            o = predict_sample(cur_req);
            if (cur_req.has_s)
                o.sample = cur_req.exp_s;
            if (cur_req.has_g)
                o.gave_up = cur_req.exp_g;
            pending_q.push_back(o);
        end
    end

    // result side: compare each popped word
    always @(posedge clk)
    begin
        draw_out_t o;
        if (rst_n && pop && !empty)
        begin
            if (pending_q.size() == 0)
            begin
                $error("unexpected result word: sample %0d gave_up %0b", sample, gave_up);
                fail_cnt++;
            end
            else
            begin
                o = pending_q.pop_front();
                if (sample !== o.sample)
                begin
                    $error("sample: expected %0d, got %0d", o.sample, sample);
                    fail_cnt++;
                end
                if (gave_up !== o.gave_up)
                begin
                    $error("gave_up: expected %0b, got %0b", o.gave_up, gave_up);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("truncated_normal_random_generator test failed");
            $finish;
        end
    end

    // receiver: random stalls per word
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = recv_burst ? 0 : $urandom_range(0, 15);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            @(negedge clk);
        end
    end

    task automatic send_word(input req_t w);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cur_req = w;
        func <= w.func;
        seed <= w.seed;
        value_a <= w.a;
        value_b <= w.b;
        value_c <= w.c;
        push <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_attempts(input logic [7:0] v);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        attempts_model = v;
    endtask

    function automatic req_t mk_req(input logic [1:0] f, input logic [30:0] sd,
                                    input logic signed [31:0] a,
                                    input logic signed [31:0] b,
                                    input logic signed [31:0] c);
        req_t w;
        w.func = f; w.seed = sd; w.a = a; w.b = b; w.c = c;
        w.has_s = 1'b0; w.exp_s = '0; w.has_g = 1'b0; w.exp_g = 1'b0;
        return w;
    endfunction

    // well-formed request: ranges that accept within a few draws
    function automatic req_t good_req();
        req_t   w;
        longint dv;
        longint mn;
        longint span;
        longint lo;
        logic [1:0] f;
        logic [30:0] sd;
        f = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 9))
            0, 1: sd = 31'($urandom_range(1, 32'h7FFF_FFFE));
            2:    sd = ($urandom_range(0, 1) != 0) ? 31'h7FFF_FFFF : 31'd1;
            default: sd = '0;
        endcase
        if (f == FUNC_NORMAL)
        begin
            dv = $urandom_range(1 << 10, 1 << 18);
            mn = dv * $urandom_range(1, 4);
            w = mk_req(f, sd, 32'(mn), 32'(($urandom_range(0, 3) == 0) ? -dv : dv),
                       32'(mn + dv * $urandom_range(1, 5)));
        end
        else
        begin
            span = $urandom_range(1 << 12, 1 << 23);
            if (f == FUNC_PERT_POS)
                lo = longint'($urandom_range(0, 50 << 16)) - span / 4;
            else
                lo = longint'($urandom_range(0, 200 << 16)) - (100 << 16);
            w = mk_req(f, sd, 32'(lo), 32'(lo + $urandom_range(0, span)), 32'(lo + span));
        end
        return w;
    endfunction

    function automatic req_t noise_req();
        return mk_req(2'($urandom), ($urandom_range(0, 3) == 0) ? 31'd0 : 31'($urandom),
                      $urandom, $urandom, $urandom);
    endfunction

    localparam int N_DIR = 18;
    req_t dir_tab[N_DIR];
    logic [7:0] phase_att[8] = '{8'd1, 8'd255, 8'd0, 8'd8, 8'd2, 8'd200, 8'd16, 8'd3};

    initial
    begin
        req_t w;
        // directed table
        dir_tab[0]  = mk_req(FUNC_NORMAL, 31'd0, 32'sh0002_0000, 32'sh0001_0000, 32'sh0010_0000);
        dir_tab[1]  = mk_req(FUNC_PERT_POS, 31'd0, 32'sh0001_0000, 32'sh0003_0000,
                             32'sh0008_0000);
        dir_tab[2]  = mk_req(FUNC_PERT_BOUNDS, 31'd12345, -32'sh0004_0000, 32'sh0000_0000,
                             32'sh0004_0000);
        dir_tab[3]  = mk_req(FUNC_UNUSED, 31'd0, -32'sh0004_0000, 32'sh0001_0000,
                             32'sh0004_0000);
        dir_tab[4]  = mk_req(FUNC_NORMAL, 31'h7FFF_FFFF, 32'sh0002_0000, 32'sh0001_0000,
                             32'sh0010_0000);
        dir_tab[5]  = mk_req(FUNC_PERT_BOUNDS, 31'h7FFF_FFFE, 32'sh8000_0000, 32'sh0000_0000,
                             32'sh7FFF_FFFF);
        dir_tab[6]  = mk_req(FUNC_NORMAL, 31'd1, 32'sh8000_0000, 32'sh7FFF_FFFF,
                             32'sh7FFF_FFFF);
        dir_tab[7]  = mk_req(FUNC_NORMAL, 31'd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                             32'sh7FFF_FFFF);
        dir_tab[8]  = mk_req(FUNC_NORMAL, 31'd0, 32'sh0001_0000, 32'sh0001_0000, 32'sh0);
        dir_tab[9]  = mk_req(FUNC_NORMAL, 31'd0, 32'sh0001_0000, 32'sh0001_0000,
                             32'sh8000_0000);
        dir_tab[10] = mk_req(FUNC_PERT_BOUNDS, 31'd0, 32'sh0004_0000, 32'sh0002_0000,
                             32'sh0001_0000);
        dir_tab[11] = mk_req(FUNC_NORMAL, 31'd0, 32'sh0003_0000, -32'sh0000_8000,
                             32'sh0008_0000);
        dir_tab[12] = mk_req(FUNC_NORMAL, 31'd0, 32'sh0003_0000, 32'sh0, 32'sh0008_0000);
        dir_tab[13] = mk_req(FUNC_PERT_POS, 31'd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                             32'sh7FFF_FFFF);
        dir_tab[14] = mk_req(FUNC_PERT_POS, 31'd77, 32'sh8000_0000, 32'sh8000_0000,
                             32'sh8000_0000);
        dir_tab[15] = mk_req(FUNC_UNUSED, 31'h7FFF_FFFF, 32'sh0004_0000, 32'sh0004_0000,
                             32'sh0004_0000);
        dir_tab[16] = mk_req(FUNC_PERT_BOUNDS, 31'd0, 32'sh8000_0000, 32'sh7FFF_FFFF,
                             32'sh0);
        dir_tab[17] = mk_req(FUNC_NORMAL, 31'd0, 32'sh0001_0000, 32'sh0001_0000,
                             -32'sh0001_0000);
        // empty ranges give up; zero deviation returns the mean
        dir_tab[8].has_g = 1'b1;  dir_tab[8].exp_g = 1'b1;
        dir_tab[9].has_g = 1'b1;  dir_tab[9].exp_g = 1'b1;
        dir_tab[10].has_g = 1'b1; dir_tab[10].exp_g = 1'b1;
        dir_tab[17].has_g = 1'b1; dir_tab[17].exp_g = 1'b1;
        dir_tab[12].has_s = 1'b1; dir_tab[12].exp_s = 32'sh0003_0000;
        dir_tab[12].has_g = 1'b1; dir_tab[12].exp_g = 1'b0;

        lcg_model = 31'd1;
        attempts_model = 8'd64;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_DIR; i++)
            send_word(dir_tab[i]);

        // random phases under several attempt limits
        for (int p = 0; p < 8; p++)
        begin
            write_attempts(phase_att[p]);
            send_burst = (p % 3 == 1);
            recv_burst = (p % 4 == 2);
            for (int i = 0; i < 170; i++)
            begin
                if (phase_att[p] <= 16 && $urandom_range(0, 3) == 0)
                    w = noise_req();
                else
                    w = good_req();
                send_word(w);
                if (i % 64 == 63)
                    send_burst = !send_burst;
            end
        end

        drain_results();
        repeat (200) @(negedge clk);
        if (fail_cnt == 0 && pending_q.size() == 0)
            $display("truncated_normal_random_generator test passed");
        else
        begin
            if (pending_q.size() != 0)
                $error("results still expected: %0d", pending_q.size());
            $display("truncated_normal_random_generator test failed");
        end
        $finish;
    end
endmodule
